FILE: hw/rtl/acc_pkg.sv
`default_nettype none
package acc_pkg;

  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [HOUR_W-1:0]   HOUR_LAST    = 5'd23;
  localparam logic [MINUTE_W-1:0] MINUTE_LAST  = 6'd59;
  localparam logic [HOUR_W-1:0]   HOUR_NONE    = 5'd24;
  localparam logic [MINUTE_W-1:0] MINUTE_NONE  = 6'd60;
  localparam logic [DAY_W-1:0]    DAY_NONE     = 5'd0;
  localparam logic [MINUTE_W-1:0] HOURLY_RESET = 6'd10;
  localparam logic [HOUR_W-1:0]   DAILY_RESET  = 5'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_HOURLY_MINUTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAILY_HOUR    = 2'd1;

  typedef struct packed {
    logic [HOUR_W-1:0]   cur_hour;
    logic [MINUTE_W-1:0] cur_minute;
    logic [DAY_W-1:0]    cur_day;
    logic                edit_pressed;
    logic                confirm_pressed;
    logic                start_set;
  } item_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   show_hour;
    logic [MINUTE_W-1:0] show_minute;
    logic                showing_alarm;
    logic                alarm_fire;
    logic                hourly_fire;
    logic                daily_fire;
    logic [PHASE_W-1:0]  set_phase;
  } res_t;

  typedef struct packed {
    logic [1:0]          hour_tens;
    logic [3:0]          hour_ones;
    logic [2:0]          minute_tens;
    logic [3:0]          minute_ones;
    logic                showing_alarm;
    logic                alarm_fire;
    logic                hourly_fire;
    logic                daily_fire;
    logic [PHASE_W-1:0]  set_phase;
  } out_t;

endpackage
`default_nettype wire

FILE: hw/rtl/acc_ctrl.sv
`default_nettype none
module acc_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             step,
  input  wire acc_pkg::item_t                   item,
  input  wire logic                             cfg_we,
  input  wire logic [acc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [acc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output acc_pkg::res_t                         res
);

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_REL_HOUR  = 8'b0000_0010,
    PH_EDIT_HOUR = 8'b0000_0100,
    PH_HELD_HOUR = 8'b0000_1000,
    PH_REL_MIN   = 8'b0001_0000,
    PH_EDIT_MIN  = 8'b0010_0000,
    PH_HELD_MIN  = 8'b0100_0000,
    PH_REL_EXIT  = 8'b1000_0000
  } phase_t;

  phase_t                           phase_r, phase_nxt;
  logic [acc_pkg::MINUTE_W-1:0]     hourly_min_r;
  logic [acc_pkg::HOUR_W-1:0]       daily_hour_r;
  logic [acc_pkg::HOUR_W-1:0]       alarm_hour_r, alarm_hour_nxt;
  logic [acc_pkg::MINUTE_W-1:0]     alarm_minute_r, alarm_minute_nxt;
  logic [acc_pkg::HOUR_W-1:0]       fired_alarm_hour_r, fired_alarm_hour_nxt;
  logic [acc_pkg::MINUTE_W-1:0]     fired_alarm_minute_r, fired_alarm_minute_nxt;
  logic [acc_pkg::HOUR_W-1:0]       fired_hourly_hour_r, fired_hourly_hour_nxt;
  logic [acc_pkg::DAY_W-1:0]        fired_daily_day_r, fired_daily_day_nxt;
  logic                             a_fire, h_fire, d_fire;

  function automatic logic [acc_pkg::PHASE_W-1:0] phase_code(input phase_t ph);
    logic [acc_pkg::PHASE_W-1:0] code;
    unique case (ph)
      PH_IDLE:      code = 3'd0;
      PH_REL_HOUR:  code = 3'd1;
      PH_EDIT_HOUR: code = 3'd2;
      PH_HELD_HOUR: code = 3'd3;
      PH_REL_MIN:   code = 3'd4;
      PH_EDIT_MIN:  code = 3'd5;
      PH_HELD_MIN:  code = 3'd6;
      PH_REL_EXIT:  code = 3'd7;
      default:      code = 3'd0;
    endcase
    return code;
  endfunction

  always_comb begin
    phase_nxt              = phase_r;
    alarm_hour_nxt         = alarm_hour_r;
    alarm_minute_nxt       = alarm_minute_r;
    fired_alarm_hour_nxt   = fired_alarm_hour_r;
    fired_alarm_minute_nxt = fired_alarm_minute_r;
    fired_hourly_hour_nxt  = fired_hourly_hour_r;
    fired_daily_day_nxt    = fired_daily_day_r;
    a_fire = 1'b0;
    h_fire = 1'b0;
    d_fire = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (item.start_set) begin
          phase_nxt = PH_REL_HOUR;
        end else begin
          if (alarm_hour_r == item.cur_hour && alarm_minute_r == item.cur_minute &&
              (fired_alarm_hour_r != item.cur_hour ||
               fired_alarm_minute_r != item.cur_minute)) begin
            a_fire                 = 1'b1;
            fired_alarm_hour_nxt   = item.cur_hour;
            fired_alarm_minute_nxt = item.cur_minute;
          end
          if (item.cur_minute == hourly_min_r && fired_hourly_hour_r != item.cur_hour) begin
            h_fire                = 1'b1;
            fired_hourly_hour_nxt = item.cur_hour;
          end
          if (item.cur_hour == daily_hour_r && fired_daily_day_r != item.cur_day) begin
            d_fire              = 1'b1;
            fired_daily_day_nxt = item.cur_day;
          end
        end
      end
      PH_REL_HOUR: begin
        if (!item.confirm_pressed) phase_nxt = PH_EDIT_HOUR;
      end
      PH_EDIT_HOUR: begin
        if (item.confirm_pressed) begin
          phase_nxt = PH_REL_MIN;
        end else if (item.edit_pressed) begin
          alarm_hour_nxt = (alarm_hour_r >= acc_pkg::HOUR_LAST) ? '0 :
                           alarm_hour_r + 5'd1;
          phase_nxt = PH_HELD_HOUR;
        end
      end
      PH_HELD_HOUR: begin
        if (!item.edit_pressed) phase_nxt = PH_EDIT_HOUR;
      end
      PH_REL_MIN: begin
        if (!item.confirm_pressed) phase_nxt = PH_EDIT_MIN;
      end
      PH_EDIT_MIN: begin
        if (item.confirm_pressed) begin
          phase_nxt = PH_REL_EXIT;
        end else if (item.edit_pressed) begin
          alarm_minute_nxt = (alarm_minute_r >= acc_pkg::MINUTE_LAST) ? '0 :
                             alarm_minute_r + 6'd1;
          phase_nxt = PH_HELD_MIN;
        end
      end
      PH_HELD_MIN: begin
        if (!item.edit_pressed) phase_nxt = PH_EDIT_MIN;
      end
      PH_REL_EXIT: begin
        if (!item.confirm_pressed) begin
          phase_nxt              = PH_IDLE;
          fired_alarm_hour_nxt   = acc_pkg::HOUR_NONE;
          fired_alarm_minute_nxt = acc_pkg::MINUTE_NONE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    res.showing_alarm = (phase_nxt != PH_IDLE);
    res.show_hour     = res.showing_alarm ? alarm_hour_nxt : item.cur_hour;
    res.show_minute   = res.showing_alarm ? alarm_minute_nxt : item.cur_minute;
    res.alarm_fire    = a_fire;
    res.hourly_fire   = h_fire;
    res.daily_fire    = d_fire;
    res.set_phase     = phase_code(phase_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r              <= PH_IDLE;
      alarm_hour_r         <= '0;
      alarm_minute_r       <= '0;
      fired_alarm_hour_r   <= acc_pkg::HOUR_NONE;
      fired_alarm_minute_r <= acc_pkg::MINUTE_NONE;
      fired_hourly_hour_r  <= acc_pkg::HOUR_NONE;
      fired_daily_day_r    <= acc_pkg::DAY_NONE;
    end else if (step) begin
      phase_r              <= phase_nxt;
      alarm_hour_r         <= alarm_hour_nxt;
      alarm_minute_r       <= alarm_minute_nxt;
      fired_alarm_hour_r   <= fired_alarm_hour_nxt;
      fired_alarm_minute_r <= fired_alarm_minute_nxt;
      fired_hourly_hour_r  <= fired_hourly_hour_nxt;
      fired_daily_day_r    <= fired_daily_day_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hourly_min_r <= acc_pkg::HOURLY_RESET;
      daily_hour_r <= acc_pkg::DAILY_RESET;
    end else if (cfg_we) begin
      if (cfg_index == acc_pkg::CFG_HOURLY_MINUTE) begin
        hourly_min_r <= cfg_data;
      end else if (cfg_index == acc_pkg::CFG_DAILY_HOUR) begin
        daily_hour_r <= cfg_data[acc_pkg::HOUR_W-1:0];
      end
    end
  end

  // pulses only come out of a sample that starts and stays idle
  a_pulse_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res.alarm_fire || res.hourly_fire || res.daily_fire) |->
      (phase_r == PH_IDLE && phase_nxt == PH_IDLE))
    else $error("pulse outside idle");

  a_alarm_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
    alarm_hour_r <= acc_pkg::HOUR_LAST)
    else $error("alarm hour out of range");

  a_alarm_minute_range: assert property (@(posedge clk) disable iff (!rst_n)
    alarm_minute_r <= acc_pkg::MINUTE_LAST)
    else $error("alarm minute out of range");

  a_alarm_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.alarm_fire) |=>
      (fired_alarm_hour_r == $past(item.cur_hour) &&
       fired_alarm_minute_r == $past(item.cur_minute)))
    else $error("alarm latch not taken");

  a_exit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == PH_REL_EXIT && !item.confirm_pressed) |=>
      (fired_alarm_hour_r == acc_pkg::HOUR_NONE &&
       fired_alarm_minute_r == acc_pkg::MINUTE_NONE))
    else $error("alarm latch not cleared on exit");

endmodule
`default_nettype wire

FILE: hw/rtl/acc_disp.sv
`default_nettype none
module acc_disp (
  input  wire acc_pkg::res_t res,
  output acc_pkg::out_t      disp
);

  function automatic logic [5:0] split_hour(input logic [acc_pkg::HOUR_W-1:0] h);
    logic [1:0] tens;
    logic [3:0] ones;
    if (h >= 5'd30) begin
      tens = 2'd3;
      ones = 4'(h - 5'd30);
    end else if (h >= 5'd20) begin
      tens = 2'd2;
      ones = 4'(h - 5'd20);
    end else if (h >= 5'd10) begin
      tens = 2'd1;
      ones = 4'(h - 5'd10);
    end else begin
      tens = 2'd0;
      ones = 4'(h);
    end
    return {tens, ones};
  endfunction

  function automatic logic [6:0] split_minute(input logic [acc_pkg::MINUTE_W-1:0] m);
    logic [2:0] tens;
    logic [3:0] ones;
    priority if (m >= 6'd60) begin
      tens = 3'd6;
      ones = 4'(m - 6'd60);
    end else if (m >= 6'd50) begin
      tens = 3'd5;
      ones = 4'(m - 6'd50);
    end else if (m >= 6'd40) begin
      tens = 3'd4;
      ones = 4'(m - 6'd40);
    end else if (m >= 6'd30) begin
      tens = 3'd3;
      ones = 4'(m - 6'd30);
    end else if (m >= 6'd20) begin
      tens = 3'd2;
      ones = 4'(m - 6'd20);
    end else if (m >= 6'd10) begin
      tens = 3'd1;
      ones = 4'(m - 6'd10);
    end else begin
      tens = 3'd0;
      ones = 4'(m);
    end
    return {tens, ones};
  endfunction

  always_comb begin
    {disp.hour_tens, disp.hour_ones}     = split_hour(res.show_hour);
    {disp.minute_tens, disp.minute_ones} = split_minute(res.show_minute);
    disp.showing_alarm = res.showing_alarm;
    disp.alarm_fire    = res.alarm_fire;
    disp.hourly_fire   = res.hourly_fire;
    disp.daily_fire    = res.daily_fire;
    disp.set_phase     = res.set_phase;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/alarm_clock_controller_top.sv
// path: an item is registered at the input, then its result at the output
// throughput: one item per cycle unless out_stall holds the output, set by
//   the input and result registers around the single mode and pulse step
// reset: synchronous active-low rst_n clears both valid flags, the mode, the
//   alarm and fired latches, and loads the trigger registers with 10 and 8
`default_nettype none
module alarm_clock_controller_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [acc_pkg::HOUR_W-1:0]      in_cur_hour,
  input  wire logic [acc_pkg::MINUTE_W-1:0]    in_cur_minute,
  input  wire logic [acc_pkg::DAY_W-1:0]       in_cur_day,
  input  wire logic                            in_edit_pressed,
  input  wire logic                            in_confirm_pressed,
  input  wire logic                            in_start_set,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           out_hour_tens,
  output logic [3:0]                           out_hour_ones,
  output logic [2:0]                           out_minute_tens,
  output logic [3:0]                           out_minute_ones,
  output logic                                 out_showing_alarm,
  output logic                                 out_alarm_fire,
  output logic                                 out_hourly_fire,
  output logic                                 out_daily_fire,
  output logic [acc_pkg::PHASE_W-1:0]          out_set_phase,
  input  wire logic                            cfg_we,
  input  wire logic [acc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [acc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic            in_valid_r;
  acc_pkg::item_t  in_item_r;
  logic            out_valid_r;
  acc_pkg::out_t   out_r;
  acc_pkg::res_t   res;
  acc_pkg::out_t   disp;
  logic            adv_out;
  logic            step;

  assign adv_out  = !out_valid_r || !out_stall;
  assign step     = in_valid_r && adv_out;
  assign in_stall = in_valid_r && !adv_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) in_valid_r <= in_valid;
      if (adv_out) out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r.cur_hour        <= in_cur_hour;
      in_item_r.cur_minute      <= in_cur_minute;
      in_item_r.cur_day         <= in_cur_day;
      in_item_r.edit_pressed    <= in_edit_pressed;
      in_item_r.confirm_pressed <= in_confirm_pressed;
      in_item_r.start_set       <= in_start_set;
    end
    if (step) out_r <= disp;
  end

  acc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (in_item_r),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  acc_disp u_disp (
    .res  (res),
    .disp (disp)
  );

  assign out_valid         = out_valid_r;
  assign out_hour_tens     = out_r.hour_tens;
  assign out_hour_ones     = out_r.hour_ones;
  assign out_minute_tens   = out_r.minute_tens;
  assign out_minute_ones   = out_r.minute_ones;
  assign out_showing_alarm = out_r.showing_alarm;
  assign out_alarm_fire    = out_r.alarm_fire;
  assign out_hourly_fire   = out_r.hourly_fire;
  assign out_daily_fire    = out_r.daily_fire;
  assign out_set_phase     = out_r.set_phase;

endmodule
`default_nettype wire
